>>> rtl/mwo_pkg.sv
// shared types, constants and elaboration-time sine helpers of the oscillator
`default_nettype none

package mwo_pkg;

  localparam int unsigned PHASE_BITS_DEF     = 32;
  localparam int unsigned SINE_ADDR_BITS_DEF = 10;
  localparam int unsigned FRAG_SAMPLES_DEF   = 1024;

  localparam int unsigned REG_BITS  = 32;
  localparam int unsigned FRAG_BITS = 10;
  localparam int unsigned WIDE_BITS = 48;

  localparam longint     HALF_PI_Q30 = 64'd1686629713;
  localparam int         FULL_SCALE  = 32767;

  typedef enum logic [1:0] {
    CFG_WAVEFORM = 2'd0,
    CFG_STEP     = 2'd1,
    CFG_OFFSET   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    WAVE_OFF      = 3'd0,
    WAVE_SINE     = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_SAW      = 3'd4
  } wave_e;

  // divisor of the n-th taylor term: (2n)(2n+1)
  function automatic longint unsigned taylor_div(input int unsigned n);
    longint unsigned d;
    case (n)
      1:       d = 64'd6;
      2:       d = 64'd20;
      3:       d = 64'd42;
      4:       d = 64'd72;
      5:       d = 64'd110;
      6:       d = 64'd156;
      7:       d = 64'd210;
      default: d = 64'd272;
    endcase
    return d;
  endfunction

  // truncating unsigned quotient by shift and subtract
  function automatic longint unsigned udiv64(input longint unsigned a,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // sine of a q30 angle in [0, pi/2], nine truncated terms
  function automatic longint sin_q30(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int unsigned n = 1; n <= 8; n++) begin
      term = udiv64((term * x2) >> 30, taylor_div(n));
      if (n[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    return sum;
  endfunction

  // quarter-wave magnitude for point j of a quarter of 2^(ab-2) points
  function automatic int quarter_value(input int unsigned j, input int unsigned ab);
    longint unsigned x;
    longint          s;
    longint          v;
    x = (longint'(j) * HALF_PI_Q30) >> (ab - 2);
    s = sin_q30(x);
    if (s < 0) s = 0;
    v = (s * FULL_SCALE + (64'sd1 <<< 29)) >>> 30;
    if (v > FULL_SCALE) v = FULL_SCALE;
    return int'(v);
  endfunction

  // full-wave table entry k of 2^ab entries
  function automatic logic signed [15:0] sine_entry(input int unsigned k,
                                                    input int unsigned ab);
    int unsigned q;
    int          v;
    q = 1 << (ab - 2);
    if (k < q)          v = quarter_value(k, ab);
    else if (k < 2 * q) v = quarter_value(2 * q - k, ab);
    else if (k < 3 * q) v = -quarter_value(k - 2 * q, ab);
    else                v = -quarter_value(4 * q - k, ab);
    return 16'(v);
  endfunction

endpackage

`default_nettype wire

>>> rtl/mwo_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module mwo_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/multi_waveform_oscillator.sv
// multi-waveform phase-accumulator oscillator, top level
`default_nettype none

// Direct digital synthesis oscillator. Each input word (restart flag in bit 0 of
// s_axis_tdata) yields one output word: a signed Q1.15 sample of the selected
// waveform (off, sine, square, triangle, sawtooth) saturated to +-32767, with
// tlast on the last sample of each fragment of FRAG_SAMPLES samples. The phase of
// a sample is the accumulator before its advance plus phase_offset; the
// accumulator then moves by phase_step, so the phase stays continuous across
// frequency changes. A new word is accepted every cycle unless both stages are full
// and m_axis_tready is low; words pass the registered state/rom read stage and the
// output register. Accumulator and fragment count live in a one-entry state ram
// that is read and written back every accepted word, with the last written value
// forwarded. Configuration writes (index 0 waveform, 1 phase_step, 2 phase_offset)
// are always ready and must only be issued while the stream is idle.
module multi_waveform_oscillator #(
  parameter int unsigned PHASE_BITS     = mwo_pkg::PHASE_BITS_DEF,
  parameter int unsigned SINE_ADDR_BITS = mwo_pkg::SINE_ADDR_BITS_DEF,
  parameter int unsigned FRAG_SAMPLES   = mwo_pkg::FRAG_SAMPLES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [15:0] sample
  output logic             m_axis_tlast,   // fragment_end

  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned FB      = mwo_pkg::FRAG_BITS;
  localparam int unsigned WB      = mwo_pkg::WIDE_BITS;
  localparam int unsigned RB      = mwo_pkg::REG_BITS;
  localparam int unsigned TBL     = 1 << SINE_ADDR_BITS;
  localparam int unsigned ST_W    = PHASE_BITS + FB;
  localparam int unsigned ST_DEPTH = 1;
  localparam int unsigned ST_AW   = 1;

  localparam logic [FB-1:0] FRAG_LAST = FB'(FRAG_SAMPLES - 1);
  localparam logic signed [16:0] POS_FS = 17'sd32767;
  localparam logic signed [16:0] NEG_FS = -17'sd32767;

  typedef logic signed [15:0] sine_rom_t [TBL];

  function automatic sine_rom_t build_rom();
    sine_rom_t r;
    for (int unsigned k = 0; k < TBL; k++) begin
      r[k] = mwo_pkg::sine_entry(k, SINE_ADDR_BITS);
    end
    return r;
  endfunction

  localparam sine_rom_t SINE_ROM = build_rom();

  typedef struct packed {
    logic [FB-1:0]         pos;
    logic [PHASE_BITS-1:0] acc;
  } osc_state_t;

  // ---------------------------------------------------------------- config
  logic [2:0]    waveform_q;
  logic [RB-1:0] step_q;
  logic [RB-1:0] offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q <= 3'(mwo_pkg::WAVE_OFF);
      step_q     <= '0;
      offset_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (mwo_pkg::cfg_idx_e'(cfg_index_i))
        mwo_pkg::CFG_WAVEFORM: waveform_q <= cfg_data_i[2:0];
        mwo_pkg::CFG_STEP:     step_q     <= cfg_data_i;
        mwo_pkg::CFG_OFFSET:   offset_q   <= cfg_data_i;
        default: ;  // indexes beyond the list are dropped
      endcase
    end
  end

  // registers are 2^-32 turn units; keep the top PHASE_BITS of the 48-bit turn
  logic [WB-1:0]         step_wide;
  logic [WB-1:0]         offset_wide;
  logic [PHASE_BITS-1:0] step_al;
  logic [PHASE_BITS-1:0] offset_al;

  assign step_wide   = {step_q, 16'd0};
  assign offset_wide = {offset_q, 16'd0};
  assign step_al     = step_wide[WB-1 -: PHASE_BITS];
  assign offset_al   = offset_wide[WB-1 -: PHASE_BITS];

  // ---------------------------------------------------------------- handshake
  logic s1_valid_q;
  logic out_valid_q;
  logic out_load;
  logic s1_load;
  logic in_accept;

  assign out_load      = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s1_load       = in_accept;

  // ---------------------------------------------------------------- state ram
  osc_state_t st_rd;
  osc_state_t st_wr;
  osc_state_t st_fwd_q;
  osc_state_t st_cur;
  logic       st_valid_q;   // state written at least once since reset
  logic       fwd_hit_q;    // written at the previous edge, ram read is stale

  mwo_ram #(
    .WIDTH (ST_W),
    .DEPTH (ST_DEPTH)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (ST_AW'(0)),
    .wdata_i (st_wr),
    .raddr_i (ST_AW'(0)),
    .rdata_o (st_rd)
  );

  always_comb begin
    if (!st_valid_q)    st_cur = '0;
    else if (fwd_hit_q) st_cur = st_fwd_q;
    else                st_cur = st_rd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      fwd_hit_q <= in_accept;
      if (in_accept) st_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) st_fwd_q <= st_wr;
  end

  // ---------------------------------------------------------------- stage 0
  logic                  restart;
  logic [PHASE_BITS-1:0] acc_in;
  logic [FB-1:0]         pos_in;
  logic [PHASE_BITS-1:0] phase;
  logic [WB-1:0]         p48;
  logic [WB-1:0]         tri_sum;
  logic [WB-1:0]         saw_sum;
  logic                  last;

  assign restart = s_axis_tdata[0];
  assign acc_in  = restart ? '0 : st_cur.acc;
  assign pos_in  = restart ? '0 : st_cur.pos;
  assign phase   = acc_in + offset_al;
  assign p48     = WB'({phase, {WB{1'b0}}} >> PHASE_BITS);
  assign tri_sum = p48 + (WB'(1) << (WB - 2));   // plus a quarter turn
  assign saw_sum = p48 + (WB'(1) << (WB - 1));   // plus a half turn
  assign last    = (pos_in >= FRAG_LAST);

  assign st_wr.acc = acc_in + step_al;
  assign st_wr.pos = last ? '0 : pos_in + FB'(1);

  // ---------------------------------------------------------------- stage 1
  logic signed [15:0] sine_q;
  logic [16:0]        tri_h_q;
  logic [15:0]        saw_g_q;
  logic               last_s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= 1'b1;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  // registered rom read, held while the stage stalls
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      sine_q    <= SINE_ROM[p48[WB-1 -: SINE_ADDR_BITS]];
      tri_h_q   <= tri_sum[WB-1 -: 17];
      saw_g_q   <= saw_sum[WB-1 -: 16];
      last_s1_q <= last;
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > POS_FS)      r = 16'(POS_FS);
    else if (v < NEG_FS) r = 16'(NEG_FS);
    else                 r = 16'(v);
    return r;
  endfunction

  logic signed [16:0] tri_val;
  logic signed [16:0] saw_val;
  logic signed [15:0] sample_d;

  // h <= 65536 is the falling half: 32768 - h, else h - 98304
  always_comb begin
    if (tri_h_q <= 17'd65536) tri_val = 17'sd32768 - $signed(tri_h_q);
    else                      tri_val = $signed(tri_h_q) - 17'sd98304;
  end

  assign saw_val = $signed({1'b0, saw_g_q}) - 17'sd32768;

  always_comb begin
    case (mwo_pkg::wave_e'(waveform_q))
      mwo_pkg::WAVE_SINE:     sample_d = sat16(17'(sine_q));
      mwo_pkg::WAVE_SQUARE:   sample_d = sine_q[15] ? 16'(NEG_FS) : 16'(POS_FS);
      mwo_pkg::WAVE_TRIANGLE: sample_d = sat16(tri_val);
      mwo_pkg::WAVE_SAW:      sample_d = sat16(saw_val);
      default:                sample_d = '0;  // off and unused codes
    endcase
  end

  // ---------------------------------------------------------------- output
  logic signed [15:0] sample_q;
  logic               tlast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      sample_q <= sample_d;
      tlast_q  <= last_s1_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = sample_q;
  assign m_axis_tlast  = tlast_q;

endmodule

`default_nettype wire

>>> sim/tb.sv
// self-checking testbench of the multi-waveform oscillator
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_HALF    = 4;
  localparam int          OSC_LATENCY = 2;
  localparam int          LONG_HOLD   = 64;
  localparam int          PEAK        = 32767;
  localparam int          FRAG_LEN    = 1024;
  localparam int          LUT_LEN     = 1024;
  localparam int          LUT_QTR     = LUT_LEN / 4;
  localparam longint      QTR_TURN_Q30 = 64'd1686629713;
  // index past the register list, the block must ignore it
  localparam logic [1:0]  CFG_UNUSED  = 2'd3;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               frag_end;
  } osc_word_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [31:0] data;
    logic        restart;
    bit          typed;      // expected word given in the row itself
    osc_word_t   want;
  } stim_row_t;

  // dut ports, all inputs known from time zero
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [0] restart, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;            // [15:0] sample
  logic        m_axis_tlast;            // fragment_end
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = 2'd0;
  logic [31:0] cfg_data_i    = 32'h0;

  multi_waveform_oscillator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // oscillator predictor: own copy of registers, accumulator and fragment count
  // ---------------------------------------------------------------------------
  logic signed [15:0] sine_lut [LUT_LEN];
  logic [2:0]         osc_wave;
  logic [31:0]        osc_step;
  logic [31:0]        osc_offset;
  logic [31:0]        osc_acc;
  int unsigned        osc_frag;

  // magnitude of point j of the first quarter wave, taylor series in q30
  function automatic int quarter_mag(int unsigned j);
    longint unsigned ang;
    longint unsigned ang_sq;
    longint unsigned t;
    longint          acc;
    longint          v;
    ang    = (longint'(j) * QTR_TURN_Q30) / LUT_QTR;
    ang_sq = (ang * ang) >> 30;
    t      = ang;
    acc    = longint'(ang);
    for (int n = 1; n <= 8; n++) begin
      t = ((t * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(t);
      else            acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    v = (acc * PEAK + (64'sd1 <<< 29)) >>> 30;
    if (v > PEAK) v = PEAK;
    return int'(v);
  endfunction

  function automatic void fill_sine_lut();
    int v;
    for (int k = 0; k < LUT_LEN; k++) begin
      // quarter-wave symmetry around pi/2, sign flip on the second half
      if (k < LUT_QTR)          v = quarter_mag(k);
      else if (k < 2 * LUT_QTR) v = quarter_mag(2 * LUT_QTR - k);
      else if (k < 3 * LUT_QTR) v = -quarter_mag(k - 2 * LUT_QTR);
      else                      v = -quarter_mag(4 * LUT_QTR - k);
      sine_lut[k] = 16'(v);
    end
  endfunction

  function automatic void osc_clear();
    osc_wave   = mwo_pkg::WAVE_OFF;
    osc_step   = '0;
    osc_offset = '0;
    osc_acc    = '0;
    osc_frag   = 0;
  endfunction

  function automatic void osc_write(logic [1:0] idx, logic [31:0] data);
    case (idx)
      mwo_pkg::CFG_WAVEFORM: osc_wave   = data[2:0];
      mwo_pkg::CFG_STEP:     osc_step   = data;
      mwo_pkg::CFG_OFFSET:   osc_offset = data;
      default: ;
    endcase
  endfunction

  // sample of the phase before the advance, then move accumulator and count
  function automatic osc_word_t next_osc_word(logic restart);
    logic [31:0]        ph;
    logic [47:0]        wide;
    logic [47:0]        tri_w;
    logic [47:0]        saw_w;
    logic [16:0]        h;
    logic signed [15:0] lut;
    int                 val;
    osc_word_t          w;
    if (restart) begin
      osc_acc  = '0;
      osc_frag = 0;
    end
    ph    = osc_acc + osc_offset;
    wide  = {ph, 16'h0000};
    lut   = sine_lut[wide[47:38]];
    tri_w = wide + (48'd1 << 46);   // quarter turn ahead
    saw_w = wide + (48'd1 << 47);   // half turn ahead
    h     = tri_w[47:31];
    case (osc_wave)
      mwo_pkg::WAVE_SINE:     val = lut;
      mwo_pkg::WAVE_SQUARE:   val = (lut >= 0) ? PEAK : -PEAK;
      mwo_pkg::WAVE_TRIANGLE: val = (h <= 17'd65536) ? 32768 - int'(h) : int'(h) - 98304;
      mwo_pkg::WAVE_SAW:      val = int'(saw_w[47:32]) - 32768;
      default:                val = 0;        // off and the unused codes
    endcase
    if (val > PEAK)  val = PEAK;
    if (val < -PEAK) val = -PEAK;
    w.sample   = 16'(val);
    w.frag_end = (osc_frag >= FRAG_LEN - 1);
    osc_acc    = osc_acc + osc_step;
    osc_frag   = w.frag_end ? 0 : osc_frag + 1;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // bookkeeping
  // ---------------------------------------------------------------------------
  osc_word_t pending_words[$];   // words still owed by the block, oldest first
  osc_word_t typed_words[$];     // meant for row-given words but never filled; typed rows go to pending_words
  int        err_cnt        = 0;
  int        words_in       = 0;
  int        words_out      = 0;
  int        frag_ends_seen = 0;
  int        restarts_sent  = 0;
  int        cfg_writes     = 0;

  // idle knobs; the idle and stall percentages change only between phases
  int        tx_idle_pct    = 0;
  int        rx_stall_pct   = 0;
  int        hold_asked     = 0;
  int        hold_given     = 0;
  int        hold_left      = 0;

  task automatic flag_error(string msg);
    if (err_cnt < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // clock and time limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("timeout with %0d words still expected", pending_words.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus a long hold-off counted here when asked
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_asked != hold_given) begin
      hold_given    = hold_given + 1;
      hold_left     = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // output checker: each accepted word against the oldest expectation
  // ---------------------------------------------------------------------------
  osc_word_t got_want;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      words_out++;
      if (m_axis_tlast === 1'b1) frag_ends_seen++;
      if (pending_words.size() == 0) begin
        flag_error($sformatf("output word %0d with nothing expected", words_out));
      end else begin
        got_want = pending_words.pop_front();
        if (m_axis_tdata !== got_want.sample)
          flag_error($sformatf("word %0d sample got %0d want %0d", words_out,
                               $signed(m_axis_tdata), got_want.sample));
        if (m_axis_tlast !== got_want.frag_end)
          flag_error($sformatf("word %0d fragment_end got %b want %b", words_out,
                               m_axis_tlast, got_want.frag_end));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus tasks
  // ---------------------------------------------------------------------------

  // offer one word; returns at the edge where it was taken
  task automatic send_word(logic restart, bit typed, osc_word_t want);
    osc_word_t w;
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, restart};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    // predictor always runs so its state stays in step with the block
    w = next_osc_word(restart);
    pending_words.push_back(typed ? want : w);
    words_in++;
    if (restart) restarts_sent++;
  endtask

  // stop offering and wait until every owed word has come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (OSC_LATENCY + 2) @(negedge clk_i);
  endtask

  // register write, only ever issued with the stream drained
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    osc_write(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return $urandom_range(32'hFFFF, 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_wave();
    logic [31:0] d;
    d = $urandom;
    // mostly the four live shapes, upper bits random since they are dropped
    if ($urandom_range(9) < 8)
      d[2:0] = 3'($urandom_range(mwo_pkg::WAVE_SAW, mwo_pkg::WAVE_SINE));
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // directed table
  // ---------------------------------------------------------------------------
  stim_row_t plan[$];

  function automatic void row_cfg(logic [1:0] idx, logic [31:0] data);
    stim_row_t r;
    r.kind    = ROW_CFG;
    r.idx     = idx;
    r.data    = data;
    r.restart = 1'b0;
    r.typed   = 1'b0;
    r.want    = '0;
    plan.push_back(r);
  endfunction

  function automatic void row_word(logic restart, bit typed = 1'b0,
                                   int smp = 0, logic last = 1'b0);
    stim_row_t r;
    r.kind        = ROW_WORD;
    r.idx         = mwo_pkg::CFG_WAVEFORM;
    r.data        = '0;
    r.restart     = restart;
    r.typed       = typed;
    r.want.sample = 16'(smp);
    r.want.frag_end = last;
    plan.push_back(r);
  endfunction

  function automatic void build_plan();
    // after reset: waveform off, zero out
    row_word(1'b0, 1'b1, 0);
    // sawtooth at its ends: half turn saturates low, just below a half turn high
    row_cfg(mwo_pkg::CFG_WAVEFORM, mwo_pkg::WAVE_SAW);
    row_cfg(mwo_pkg::CFG_OFFSET, 32'h8000_0000);
    row_word(1'b1, 1'b1, -PEAK);
    row_cfg(mwo_pkg::CFG_OFFSET, 32'h7FFF_FFFF);
    row_word(1'b0, 1'b1, PEAK);
    row_cfg(mwo_pkg::CFG_OFFSET, 32'h0000_0000);
    row_word(1'b0, 1'b1, 0);
    // triangle: zero crossing, trough and peak
    row_cfg(mwo_pkg::CFG_WAVEFORM, mwo_pkg::WAVE_TRIANGLE);
    row_word(1'b0, 1'b1, 0);
    row_cfg(mwo_pkg::CFG_OFFSET, 32'h4000_0000);
    row_word(1'b0, 1'b1, -PEAK);
    row_cfg(mwo_pkg::CFG_OFFSET, 32'hC000_0000);
    row_word(1'b0, 1'b1, PEAK);
    // square: negative lobe and the zero entry counted as positive
    row_cfg(mwo_pkg::CFG_WAVEFORM, mwo_pkg::WAVE_SQUARE);
    row_word(1'b0, 1'b1, -PEAK);
    row_cfg(mwo_pkg::CFG_OFFSET, 32'h0000_0000);
    row_word(1'b0, 1'b1, PEAK);
    // sine at zero, crest and trough
    row_cfg(mwo_pkg::CFG_WAVEFORM, mwo_pkg::WAVE_SINE);
    row_word(1'b0, 1'b1, 0);
    row_cfg(mwo_pkg::CFG_OFFSET, 32'h4000_0000);
    row_word(1'b0);
    row_cfg(mwo_pkg::CFG_OFFSET, 32'hC000_0000);
    row_word(1'b0);
    // unused waveform codes give silence
    row_cfg(mwo_pkg::CFG_WAVEFORM, 32'h0000_0005);
    row_word(1'b0, 1'b1, 0);
    row_cfg(mwo_pkg::CFG_WAVEFORM, 32'hFFFF_FFFF);
    row_word(1'b0, 1'b1, 0);
    // write past the register list must change nothing
    row_cfg(CFG_UNUSED, 32'h1234_5678);
    row_word(1'b0, 1'b1, 0);
    // largest step: accumulator wraps each word, restart pulls it back
    row_cfg(mwo_pkg::CFG_WAVEFORM, mwo_pkg::WAVE_SAW);
    row_cfg(mwo_pkg::CFG_STEP, 32'hFFFF_FFFF);
    row_cfg(mwo_pkg::CFG_OFFSET, 32'h0000_0000);
    row_word(1'b1);
    row_word(1'b0);
    row_word(1'b0);
    row_cfg(mwo_pkg::CFG_STEP, 32'h8000_0000);
    row_word(1'b0);
    row_word(1'b0);
    row_word(1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    osc_word_t   none;
    int          n_words;
    int          phase_no;
    none = '0;
    fill_sine_lut();
    osc_clear();
    build_plan();

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // directed part, no idling
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].data);
      else send_word(plan[i].restart, plan[i].typed, plan[i].want);
    end

    // random phases, each with fresh settings and its own idle pattern;
    // no restarts here so the fragment count keeps climbing toward its wrap
    for (phase_no = 0; phase_no < 8; phase_no++) begin
      case (phase_no % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 48; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 48; end
        default: begin tx_idle_pct = 9; rx_stall_pct = 9; end
      endcase
      write_reg(mwo_pkg::CFG_WAVEFORM, pick_wave());
      write_reg(mwo_pkg::CFG_STEP, pick_step());
      write_reg(mwo_pkg::CFG_OFFSET, ($urandom_range(3) == 0) ? pick_step() : $urandom);
      if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, $urandom);
      for (n_words = 0; n_words < 90; n_words++) begin
        // long receiver hold-off while the sender keeps pushing
        if (n_words == 20 && phase_no % 4 == 0) hold_asked++;
        // sender pauses until the block has delivered everything
        if (n_words == 45 && phase_no % 4 == 1) wait_drained();
        send_word(1'b0, 1'b0, none);
      end
    end

    // keep going without restart until the fragment counter wraps
    tx_idle_pct  = 9;
    rx_stall_pct = 9;
    write_reg(mwo_pkg::CFG_WAVEFORM, mwo_pkg::WAVE_TRIANGLE);
    write_reg(mwo_pkg::CFG_STEP, $urandom);
    do send_word(1'b0, 1'b0, none); while (osc_frag != 0);
    // then a short stretch with random restarts
    for (n_words = 0; n_words < 40; n_words++)
      send_word($urandom_range(7) == 0, 1'b0, none);

    // let every owed word out, then leave spare time for strays
    wait_drained();
    repeat (OSC_LATENCY + 8) @(posedge clk_i);
    if (pending_words.size() != 0)
      flag_error($sformatf("%0d expected words never came", pending_words.size()));

    $display("covered %0d words in, %0d out, %0d restarts, %0d fragment ends,",
             words_in, words_out, restarts_sent, frag_ends_seen);
    $display("%0d register writes over all five shapes and unused codes, %0d errors",
             cfg_writes, err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
